// ----- hw/rtl/uers_pkg.sv -----
// uers_pkg: types, codes and defaults shared by the ecu reset service block
// used by uers_cfg_regs, uers_engine and uds_ecu_reset_service
`default_nettype none

package uers_pkg;

  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int NUM_TYPE_COUNTS = 3;

  localparam logic [11:0] MIN_REQ_LEN   = 12'd2;
  localparam logic [15:0] DEFAULT_DELAY = 16'd10;
  localparam logic [3:0]  DEFAULT_MASK  = 4'd7;

  localparam logic [7:0] NRC_NONE  = 8'h00;
  localparam logic [7:0] NRC_SUBFN = 8'h12;
  localparam logic [7:0] NRC_LEN   = 8'h13;
  localparam logic [7:0] NRC_BUSY  = 8'h21;
  localparam logic [7:0] NRC_COND  = 8'h22;
  localparam logic [7:0] POS_SID   = 8'h51;

  localparam logic [6:0] SUB_HARD      = 7'd1;
  localparam logic [6:0] SUB_KEY_OFFON = 7'd2;
  localparam logic [6:0] SUB_SOFT      = 7'd3;
  localparam logic [6:0] SUB_RAPID_EN  = 7'd4;
  localparam logic [6:0] SUB_RAPID_DIS = 7'd5;

  localparam logic [1:0] SESS_PROG = 2'd1;
  localparam logic [1:0] SESS_EXT  = 2'd2;

  localparam logic [1:0] RAPID_NONE = 2'd0;
  localparam logic [1:0] RAPID_EN   = 2'd1;
  localparam logic [1:0] RAPID_DIS  = 2'd2;

  localparam logic [1:0] RESP_LEN_NONE  = 2'd0;
  localparam logic [1:0] RESP_LEN_SHORT = 2'd2;
  localparam logic [1:0] RESP_LEN_PDT   = 2'd3;

  localparam logic [1:0] MS_IDLE    = 2'd0;
  localparam logic [1:0] MS_PENDING = 2'd1;
  localparam logic [1:0] MS_EXEC    = 2'd2;

  localparam logic [2:0] STAT_TOTAL = 3'd0;

  typedef enum logic [2:0] {
    CMD_REQUEST = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_CANCEL  = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SUPPORTED_MASK = 3'd0,
    REG_REQ_PROG       = 3'd1,
    REG_REQ_EXT        = 3'd2,
    REG_RESET_DELAY    = 3'd3,
    REG_PDT_AVAILABLE  = 3'd4,
    REG_PDT_SECONDS    = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PENDING = 3'b010,
    PH_EXEC    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] req_length;
    logic [7:0]  sub_byte;
    logic [15:0] source_address;
    logic [1:0]  session;
    logic [15:0] elapsed_ms;
    logic [2:0]  stat_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  nrc;
    logic [7:0]  resp_sid;
    logic [6:0]  resp_sub;
    logic [7:0]  resp_pdt;
    logic [1:0]  resp_length;
    logic        suppressed;
    logic [1:0]  rapid_action;
    logic [1:0]  reset_action;
    logic [1:0]  machine_state;
    logic [1:0]  pending_kind;
    logic [31:0] stat_value;
    logic [15:0] requester;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  supported_mask;
    logic        require_programming;
    logic        require_extended;
    logic [15:0] reset_delay;
    logic        power_down_available;
    logic [7:0]  power_down_seconds;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/uers_cfg_regs.sv -----
// uers_cfg_regs: configuration register file of the ecu reset service block
// depends on uers_pkg
`default_nettype none

module uers_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire logic [2:0]     wr_index,
  input  wire logic [15:0]    wr_data,
  output uers_pkg::cfg_t      cfg
);

  uers_pkg::cfg_t cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.supported_mask       <= uers_pkg::DEFAULT_MASK;
      cfg_regs.require_programming  <= 1'b0;
      cfg_regs.require_extended     <= 1'b0;
      cfg_regs.reset_delay          <= uers_pkg::DEFAULT_DELAY;
      cfg_regs.power_down_available <= 1'b0;
      cfg_regs.power_down_seconds   <= 8'd0;
    end else if (wr_en) begin
      case (wr_index)
        uers_pkg::REG_SUPPORTED_MASK: cfg_regs.supported_mask       <= wr_data[3:0];
        uers_pkg::REG_REQ_PROG:       cfg_regs.require_programming  <= wr_data[0];
        uers_pkg::REG_REQ_EXT:        cfg_regs.require_extended     <= wr_data[0];
        uers_pkg::REG_RESET_DELAY:    cfg_regs.reset_delay          <= wr_data;
        uers_pkg::REG_PDT_AVAILABLE:  cfg_regs.power_down_available <= wr_data[0];
        uers_pkg::REG_PDT_SECONDS:    cfg_regs.power_down_seconds   <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_regs;

endmodule

`default_nettype wire

// ----- hw/rtl/uers_engine.sv -----
// uers_engine: service state, statistics counters and the per-transaction decision logic
// depends on uers_pkg; driven by the pipeline in uds_ecu_reset_service
`default_nettype none

module uers_engine #(
  parameter int COUNTER_WIDTH = uers_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire uers_pkg::in_item_t  item,
  input  wire uers_pkg::cfg_t      cfg,
  output uers_pkg::out_item_t      result
);

  localparam int NTC = uers_pkg::NUM_TYPE_COUNTS;

  uers_pkg::phase_t         phase, phase_next;
  logic [1:0]               pending_type, pending_type_next;
  logic [15:0]              delay_left, delay_left_next;
  logic [15:0]              tester_addr, tester_addr_next;
  logic [COUNTER_WIDTH-1:0] total_count, total_count_next;
  logic [COUNTER_WIDTH-1:0] type_counts [NTC];
  logic [COUNTER_WIDTH-1:0] type_counts_next [NTC];

  logic [6:0]  sub;
  logic        quiet;
  logic [1:0]  mask_bit;
  logic        elevated;
  logic        cond_fail;
  logic [7:0]  nrc_code;
  logic [1:0]  type_idx;
  logic [COUNTER_WIDTH-1:0] stat_sel;
  logic [63:0] stat_ext;

  assign sub      = item.sub_byte[6:0];
  assign quiet    = item.sub_byte[7];
  assign mask_bit = (sub >= uers_pkg::SUB_RAPID_EN) ? 2'd3 : 2'(sub - 7'd1);
  assign elevated = (item.session == uers_pkg::SESS_PROG) ||
                    (item.session == uers_pkg::SESS_EXT);
  assign cond_fail =
      ((sub == uers_pkg::SUB_HARD) && cfg.require_programming &&
       (item.session != uers_pkg::SESS_PROG)) ||
      ((sub == uers_pkg::SUB_SOFT) && cfg.require_extended && !elevated) ||
      ((sub == uers_pkg::SUB_KEY_OFFON) && !elevated);
  assign type_idx = 2'(sub - 7'd1);

  always_comb begin
    if (item.req_length < uers_pkg::MIN_REQ_LEN) begin
      nrc_code = uers_pkg::NRC_LEN;
    end else if (phase != uers_pkg::PH_IDLE) begin
      nrc_code = uers_pkg::NRC_BUSY;
    end else if ((sub < uers_pkg::SUB_HARD) || (sub > uers_pkg::SUB_RAPID_DIS)) begin
      nrc_code = uers_pkg::NRC_SUBFN;
    end else if (!cfg.supported_mask[mask_bit]) begin
      nrc_code = uers_pkg::NRC_SUBFN;
    end else if (cond_fail) begin
      nrc_code = uers_pkg::NRC_COND;
    end else begin
      nrc_code = uers_pkg::NRC_NONE;
    end
  end

  always_comb begin
    phase_next        = phase;
    pending_type_next = pending_type;
    delay_left_next   = delay_left;
    tester_addr_next  = tester_addr;
    total_count_next  = total_count;
    for (int i = 0; i < NTC; i++) begin
      type_counts_next[i] = type_counts[i];
    end
    result = '0;

    case (item.cmd)
      uers_pkg::CMD_REQUEST: begin
        result.nrc = nrc_code;
        if (nrc_code == uers_pkg::NRC_NONE) begin
          if (sub >= uers_pkg::SUB_RAPID_EN) begin
            result.rapid_action = (sub == uers_pkg::SUB_RAPID_EN) ?
                                  uers_pkg::RAPID_EN : uers_pkg::RAPID_DIS;
            if (quiet) begin
              result.suppressed = 1'b1;
            end else begin
              result.resp_sid    = uers_pkg::POS_SID;
              result.resp_sub    = sub;
              result.resp_length = uers_pkg::RESP_LEN_SHORT;
            end
          end else begin
            total_count_next = total_count + COUNTER_WIDTH'(1);
            type_counts_next[type_idx] = type_counts[type_idx] + COUNTER_WIDTH'(1);
            phase_next        = uers_pkg::PH_PENDING;
            pending_type_next = sub[1:0];
            delay_left_next   = cfg.reset_delay;
            tester_addr_next  = item.source_address;
            if (quiet) begin
              result.suppressed = 1'b1;
            end else begin
              result.resp_sid = uers_pkg::POS_SID;
              result.resp_sub = sub;
              if (cfg.power_down_available) begin
                result.resp_pdt    = cfg.power_down_seconds;
                result.resp_length = uers_pkg::RESP_LEN_PDT;
              end else begin
                result.resp_length = uers_pkg::RESP_LEN_SHORT;
              end
            end
          end
        end
      end
      uers_pkg::CMD_TICK: begin
        if (phase == uers_pkg::PH_PENDING) begin
          if (delay_left > item.elapsed_ms) begin
            delay_left_next = delay_left - item.elapsed_ms;
          end else begin
            delay_left_next     = 16'd0;
            phase_next          = uers_pkg::PH_EXEC;
            result.reset_action = pending_type;
          end
        end
      end
      uers_pkg::CMD_CANCEL: begin
        if (phase != uers_pkg::PH_IDLE) begin
          phase_next        = uers_pkg::PH_IDLE;
          pending_type_next = 2'd0;
          delay_left_next   = 16'd0;
        end
      end
      uers_pkg::CMD_CLEAR: begin
        total_count_next = '0;
        for (int i = 0; i < NTC; i++) begin
          type_counts_next[i] = '0;
        end
      end
      default: begin
      end
    endcase

    // status after the step
    case (phase_next)
      uers_pkg::PH_PENDING: result.machine_state = uers_pkg::MS_PENDING;
      uers_pkg::PH_EXEC:    result.machine_state = uers_pkg::MS_EXEC;
      default:              result.machine_state = uers_pkg::MS_IDLE;
    endcase
    result.pending_kind = (phase_next != uers_pkg::PH_IDLE) ? pending_type_next : 2'd0;
    result.requester    = tester_addr_next;
    result.stat_value   = stat_ext[31:0];
  end

  // rapid shutdown never counts, so only hard, key off-on and soft have counters
  always_comb begin
    if (item.stat_index == uers_pkg::STAT_TOTAL) begin
      stat_sel = total_count_next;
    end else if (item.stat_index <= 3'(NTC)) begin
      stat_sel = type_counts_next[2'(item.stat_index - 3'd1)];
    end else begin
      stat_sel = '0;
    end
  end

  assign stat_ext = 64'(stat_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= uers_pkg::PH_IDLE;
      pending_type <= 2'd0;
      delay_left   <= 16'd0;
      tester_addr  <= 16'd0;
      total_count  <= '0;
      for (int i = 0; i < NTC; i++) begin
        type_counts[i] <= '0;
      end
    end else if (step) begin
      phase        <= phase_next;
      pending_type <= pending_type_next;
      delay_left   <= delay_left_next;
      tester_addr  <= tester_addr_next;
      total_count  <= total_count_next;
      for (int i = 0; i < NTC; i++) begin
        type_counts[i] <= type_counts_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/uds_ecu_reset_service.sv -----
// uds_ecu_reset_service: top level, input register, result register and assertions
// depends on uers_pkg, uers_cfg_regs and uers_engine
`default_nettype none

// ECU reset service (0x11) engine. Each input transaction carries one command:
// a reset request, a millisecond tick, a cancel, a statistics clear or a
// query, and produces exactly one result transaction, offered on the output
// after it has been held in the input register and its outcome has been
// captured in the result register. The decision for a
// transaction is a single pass of compare and subtract logic against the
// service state, so one transaction is taken every cycle while results are
// being drained; in_ready drops only when both the input register and the
// result register hold a transaction that the output side has not taken.
// Configuration writes take effect the cycle after cfg_valid and should be
// made while no transaction is in flight; cfg_ready is always high.
module uds_ecu_reset_service #(
  parameter int COUNTER_WIDTH = uers_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire uers_pkg::in_item_t  in_item,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output uers_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  uers_pkg::cfg_t      cfg;
  uers_pkg::in_item_t  hold_item;
  uers_pkg::out_item_t result;
  logic                hold_valid;
  logic                advance;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || advance;

  uers_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  uers_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (hold_valid && out_valid && !out_ready))
    else $error("input stalled while the pipeline could move");

  a_reset_action_exec: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.reset_action != 2'd0)) |->
      (out_item.machine_state == uers_pkg::MS_EXEC))
    else $error("reset action given outside the executing state");

  a_negative_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.nrc != uers_pkg::NRC_NONE)) |->
      ((out_item.resp_length == uers_pkg::RESP_LEN_NONE) && !out_item.suppressed &&
       (out_item.resp_sid == 8'd0) && (out_item.rapid_action == uers_pkg::RAPID_NONE)))
    else $error("negative response carries positive response fields");

  a_positive_sid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.resp_length != uers_pkg::RESP_LEN_NONE)) |->
      ((out_item.resp_sid == uers_pkg::POS_SID) && (out_item.nrc == uers_pkg::NRC_NONE)))
    else $error("positive response without its service id");

endmodule

`default_nettype wire
